// File: hw/rtl/fcf_pkg.sv
// Shared types, constants and fixed-point helpers for the boundary face flux block.
// Used by the datapath modules, the divider and the port checker.
// No dependencies.
package fcf_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int EF_W = 21;
  localparam logic [EF_W-1:0] EF_RESET = 21'd229376;

  // Side codes whose normal points the other way.
  localparam logic [1:0] SIDE_RIGHT = 2'd1;
  localparam logic [1:0] SIDE_TOP   = 2'd2;

  // Quotient of pressure over density: 31 bits, four bits per stage.
  localparam int DIV_QW     = 31;
  localparam int DIV_BPS    = 4;
  localparam int DIV_STAGES = (DIV_QW + DIV_BPS - 1) / DIV_BPS;

  localparam int NUM_STAGES = 13;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [63:0] w64_t;

  typedef struct packed {
    logic clip;
    q32_t val;
  } sat_t;

  localparam w64_t Q_MAX = 64'sd2147483647;
  localparam w64_t Q_MIN = -64'sd2147483648;

  // Product rounding: add half an LSB, then arithmetic shift.
  function automatic w64_t rnd(input w64_t p, input int f);
    return (p + (w64_t'(1) <<< (f - 1))) >>> f;
  endfunction

  function automatic w64_t half64(input w64_t x);
    return (x + 64'sd1) >>> 1;
  endfunction

  function automatic sat_t sat32(input w64_t x);
    sat_t r;
    if (x > Q_MAX) begin
      r.clip = 1'b1;
      r.val  = 32'sh7fffffff;
    end else if (x < Q_MIN) begin
      r.clip = 1'b1;
      r.val  = 32'sh80000000;
    end else begin
      r.clip = 1'b0;
      r.val  = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/boundary_face_central_flux.sv
// Top level: averaged central convective flux of one boundary face per beat, Q16.16.
// Depends on fcf_pkg, fcf_div and fcf_delay.
//
//  channel | direction | tdata                                | tuser
//  in_     | slave     | normals, ghost and interior states   | side
//  out_    | master    | mass, x-mom, y-mom, energy fluxes    | saturated
//  cfg_    | write     | enthalpy factor (21 bits)            | -
//
// One beat per cycle in and out while out_tready stays high; a beat passes stage 1, the 8-stage quotient
// pipeline, then the enthalpy and energy multiply stages.
// Each stage stalls only when it holds a beat and the stage after it is blocked,
// so bubbles close up while the output register waits.
// Reset clears all valid bits and loads the enthalpy factor with 3.5.
module boundary_face_central_flux import fcf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  // normal_x, normal_y, ghost_density, ghost_vel_x, ghost_vel_y, ghost_pressure,
  // inner_density, inner_vel_x, inner_vel_y, inner_pressure, 4 zero bits
  input  logic [319:0]    in_tdata,
  // side
  input  logic [1:0]      in_tuser,
  output logic            out_tvalid,
  input  logic            out_tready,
  // flux_mass, flux_xmom, flux_ymom, flux_energy
  output logic [127:0]    out_tdata,
  // saturated
  output logic            out_tuser,
  input  logic            cfg_wr_en,
  input  logic [EF_W-1:0] cfg_wr_data
);

  localparam int RW = 65 - FRAC_BITS;
  localparam int KW = RW + 1;

  // Input beat fields.
  q32_t        normal_x, normal_y, ghost_vel_x, ghost_vel_y, inner_vel_x, inner_vel_y;
  logic [30:0] ghost_density, ghost_pressure, inner_density, inner_pressure;

  assign normal_x       = in_tdata[31:0];
  assign normal_y       = in_tdata[63:32];
  assign ghost_density  = in_tdata[94:64];
  assign ghost_vel_x    = in_tdata[126:95];
  assign ghost_vel_y    = in_tdata[158:127];
  assign ghost_pressure = in_tdata[189:159];
  assign inner_density  = in_tdata[220:190];
  assign inner_vel_x    = in_tdata[252:221];
  assign inner_vel_y    = in_tdata[284:253];
  assign inner_pressure = in_tdata[315:285];

  logic [EF_W-1:0] ef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ef_r <= EF_RESET;
    end else if (cfg_wr_en) begin
      ef_r <= cfg_wr_data;
    end
  end

  // Valid bits and per-stage enables.
  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] en;

  assign en[NUM_STAGES] = !v_r[NUM_STAGES] || out_tready;
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = !v_r[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_tvalid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[1];
  assign out_tvalid = v_r[NUM_STAGES];

  // Stage 1: normal orientation, pressure average.
  sat_t        sx_nxt, sy_nxt;
  logic [31:0] psum;
  logic        flip;

  assign flip = (in_tuser == SIDE_RIGHT) || (in_tuser == SIDE_TOP);
  assign psum = {1'b0, ghost_pressure} + {1'b0, inner_pressure} + 32'd1;

  always_comb begin
    if (flip) begin
      sx_nxt = sat32(-w64_t'(normal_x));
      sy_nxt = sat32(-w64_t'(normal_y));
    end else begin
      sx_nxt = '{clip: 1'b0, val: normal_x};
      sy_nxt = '{clip: 1'b0, val: normal_y};
    end
  end

  q32_t        sx1_r, sy1_r, ug1_r, vg1_r, ui1_r, vi1_r;
  logic [30:0] rg1_r, pg1_r, ri1_r, pi1_r, pavg1_r;
  logic        fl1_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sx1_r   <= sx_nxt.val;
      sy1_r   <= sy_nxt.val;
      fl1_r   <= sx_nxt.clip | sy_nxt.clip;
      ug1_r   <= ghost_vel_x;
      vg1_r   <= ghost_vel_y;
      ui1_r   <= inner_vel_x;
      vi1_r   <= inner_vel_y;
      rg1_r   <= ghost_density;
      pg1_r   <= ghost_pressure;
      ri1_r   <= inner_density;
      pi1_r   <= inner_pressure;
      pavg1_r <= psum[31:1];
    end
  end

  // Stage 2: squares, dot-product terms and pressure terms.
  w64_t        m_uug2_r, m_vvg2_r, m_uui2_r, m_vvi2_r;
  w64_t        m_dxg2_r, m_dyg2_r, m_dxi2_r, m_dyi2_r, m_psx2_r, m_psy2_r;
  logic [30:0] rg2_r, ri2_r;
  logic        fl2_r;
  q32_t        pavg_s;

  assign pavg_s = {1'b0, pavg1_r};

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m_uug2_r <= ug1_r * ug1_r;
      m_vvg2_r <= vg1_r * vg1_r;
      m_uui2_r <= ui1_r * ui1_r;
      m_vvi2_r <= vi1_r * vi1_r;
      m_dxg2_r <= ug1_r * sx1_r;
      m_dyg2_r <= vg1_r * sy1_r;
      m_dxi2_r <= ui1_r * sx1_r;
      m_dyi2_r <= vi1_r * sy1_r;
      m_psx2_r <= pavg_s * sx1_r;
      m_psy2_r <= pavg_s * sy1_r;
      rg2_r    <= rg1_r;
      ri2_r    <= ri1_r;
      fl2_r    <= fl1_r;
    end
  end

  // Stage 3: kinetic terms and saturated dot products.
  sat_t dotg_nxt, doti_nxt;

  assign dotg_nxt = sat32(rnd(m_dxg2_r, FRAC_BITS) + rnd(m_dyg2_r, FRAC_BITS));
  assign doti_nxt = sat32(rnd(m_dxi2_r, FRAC_BITS) + rnd(m_dyi2_r, FRAC_BITS));

  logic signed [KW-1:0] keg3_r, kei3_r;
  logic signed [RW-1:0] psx3_r, psy3_r;
  q32_t                 dotg3_r, doti3_r;
  logic [30:0]          rg3_r, ri3_r;
  logic                 fl3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      keg3_r  <= KW'(half64(rnd(m_uug2_r, FRAC_BITS) + rnd(m_vvg2_r, FRAC_BITS)));
      kei3_r  <= KW'(half64(rnd(m_uui2_r, FRAC_BITS) + rnd(m_vvi2_r, FRAC_BITS)));
      psx3_r  <= RW'(rnd(m_psx2_r, FRAC_BITS));
      psy3_r  <= RW'(rnd(m_psy2_r, FRAC_BITS));
      dotg3_r <= dotg_nxt.val;
      doti3_r <= doti_nxt.val;
      rg3_r   <= rg2_r;
      ri3_r   <= ri2_r;
      fl3_r   <= fl2_r | dotg_nxt.clip | doti_nxt.clip;
    end
  end

  // Stage 4: normal mass flux products.
  w64_t m_qg4_r, m_qi4_r;
  logic fl4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      m_qg4_r <= dotg3_r * signed'({1'b0, rg3_r});
      m_qi4_r <= doti3_r * signed'({1'b0, ri3_r});
      fl4_r   <= fl3_r;
    end
  end

  // Stage 5: saturated normal mass fluxes.
  sat_t qg_nxt, qi_nxt;

  assign qg_nxt = sat32(rnd(m_qg4_r, FRAC_BITS));
  assign qi_nxt = sat32(rnd(m_qi4_r, FRAC_BITS));

  q32_t qg5_r, qi5_r;
  logic fl5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      qg5_r <= qg_nxt.val;
      qi5_r <= qi_nxt.val;
      fl5_r <= fl4_r | qg_nxt.clip | qi_nxt.clip;
    end
  end

  logic [127:0] vel5;
  q32_t         ug5, vg5, ui5, vi5;

  fcf_delay #(.W(128), .N(4)) u_vel_dly (
    .clk (clk),
    .en  (en[5:2]),
    .d   ({vi1_r, ui1_r, vg1_r, ug1_r}),
    .q   (vel5)
  );

  assign ug5 = vel5[31:0];
  assign vg5 = vel5[63:32];
  assign ui5 = vel5[95:64];
  assign vi5 = vel5[127:96];

  // Stage 6: momentum products and mass flux.
  sat_t fm_nxt;

  assign fm_nxt = sat32(half64(w64_t'(qg5_r) + w64_t'(qi5_r)));

  w64_t m_xg6_r, m_xi6_r, m_yg6_r, m_yi6_r;
  q32_t qg6_r, qi6_r, fm6_r;
  logic fl6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      m_xg6_r <= qg5_r * ug5;
      m_xi6_r <= qi5_r * ui5;
      m_yg6_r <= qg5_r * vg5;
      m_yi6_r <= qi5_r * vi5;
      qg6_r   <= qg5_r;
      qi6_r   <= qi5_r;
      fm6_r   <= fm_nxt.val;
      fl6_r   <= fl5_r | fm_nxt.clip;
    end
  end

  logic [2*RW-1:0]      ps6;
  logic signed [RW-1:0] psx6, psy6;

  fcf_delay #(.W(2*RW), .N(3)) u_ps_dly (
    .clk (clk),
    .en  (en[6:4]),
    .d   ({psy3_r, psx3_r}),
    .q   (ps6)
  );

  assign psx6 = ps6[RW-1:0];
  assign psy6 = ps6[2*RW-1:RW];

  // Stage 7: momentum fluxes.
  sat_t fx_nxt, fy_nxt;

  assign fx_nxt = sat32(half64(rnd(m_xg6_r, FRAC_BITS) + rnd(m_xi6_r, FRAC_BITS))
                        + w64_t'(psx6));
  assign fy_nxt = sat32(half64(rnd(m_yg6_r, FRAC_BITS) + rnd(m_yi6_r, FRAC_BITS))
                        + w64_t'(psy6));

  q32_t fm7_r, fx7_r, fy7_r;
  logic fl7_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      fm7_r <= fm6_r;
      fx7_r <= fx_nxt.val;
      fy7_r <= fy_nxt.val;
      fl7_r <= fl6_r | fx_nxt.clip | fy_nxt.clip;
    end
  end

  logic [96:0] grp12;

  fcf_delay #(.W(97), .N(5)) u_flux_dly (
    .clk (clk),
    .en  (en[12:8]),
    .d   ({fl7_r, fy7_r, fx7_r, fm7_r}),
    .q   (grp12)
  );

  logic [63:0] qs11;
  q32_t        qg11, qi11;

  fcf_delay #(.W(64), .N(5)) u_qs_dly (
    .clk (clk),
    .en  (en[11:7]),
    .d   ({qi6_r, qg6_r}),
    .q   (qs11)
  );

  assign qg11 = qs11[31:0];
  assign qi11 = qs11[63:32];

  logic [2*KW-1:0]      ke10;
  logic signed [KW-1:0] keg10, kei10;

  fcf_delay #(.W(2*KW), .N(7)) u_ke_dly (
    .clk (clk),
    .en  (en[10:4]),
    .d   ({kei3_r, keg3_r}),
    .q   (ke10)
  );

  assign keg10 = ke10[KW-1:0];
  assign kei10 = ke10[2*KW-1:KW];

  // Stages 2 to 9: pressure over density.
  sat_t quo_g, quo_i;

  fcf_div #(.FRAC_BITS(FRAC_BITS)) u_div_g (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .rho (rg1_r),
    .p   (pg1_r),
    .quo (quo_g)
  );

  fcf_div #(.FRAC_BITS(FRAC_BITS)) u_div_i (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .rho (ri1_r),
    .p   (pi1_r),
    .quo (quo_i)
  );

  // Stage 10: enthalpy factor times quotient.
  logic [EF_W+30:0] m_hg10_r, m_hi10_r;
  logic             fl10_r;

  always_ff @(posedge clk) begin
    if (en[10]) begin
      m_hg10_r <= ef_r * quo_g.val[30:0];
      m_hi10_r <= ef_r * quo_i.val[30:0];
      fl10_r   <= quo_g.clip | quo_i.clip;
    end
  end

  // Stage 11: total enthalpies.
  sat_t hg_nxt, hi_nxt;

  assign hg_nxt = sat32(rnd(w64_t'({1'b0, m_hg10_r}), FRAC_BITS) + w64_t'(keg10));
  assign hi_nxt = sat32(rnd(w64_t'({1'b0, m_hi10_r}), FRAC_BITS) + w64_t'(kei10));

  q32_t hg11_r, hi11_r;
  logic fl11_r;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      hg11_r <= hg_nxt.val;
      hi11_r <= hi_nxt.val;
      fl11_r <= fl10_r | hg_nxt.clip | hi_nxt.clip;
    end
  end

  // Stage 12: energy products.
  w64_t m_eg12_r, m_ei12_r;
  logic fl12_r;

  always_ff @(posedge clk) begin
    if (en[12]) begin
      m_eg12_r <= qg11 * hg11_r;
      m_ei12_r <= qi11 * hi11_r;
      fl12_r   <= fl11_r;
    end
  end

  // Stage 13: energy flux and output register.
  sat_t fe_nxt;

  assign fe_nxt = sat32(half64(rnd(m_eg12_r, FRAC_BITS) + rnd(m_ei12_r, FRAC_BITS)));

  logic [127:0] out_tdata_r;
  logic         out_tuser_r;

  always_ff @(posedge clk) begin
    if (en[13]) begin
      out_tdata_r <= {fe_nxt.val, grp12[95:0]};
      out_tuser_r <= grp12[96] | fl12_r | fe_nxt.clip;
    end
  end

  assign out_tdata = out_tdata_r;
  assign out_tuser = out_tuser_r;

endmodule

// File: hw/rtl/fcf_delay.sv
// Delay line with one enable per stage, keeping side data aligned with the main pipeline.
// Depends on nothing.
module fcf_delay #(
  parameter int W = 32,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic [N-1:0] en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sr_r[0] <= d;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sr_r[k] <= sr_r[k-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

// File: hw/rtl/fcf_div.sv
// Pipelined restoring divider: (p << FRAC_BITS) / rho, saturated to 32-bit signed.
// Depends on fcf_pkg.
module fcf_div import fcf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [30:0]           rho,
  input  logic [30:0]           p,
  output sat_t                  quo
);

  localparam int SH = DIV_QW - FRAC_BITS;
  localparam int CW = DIV_QW + SH;
  localparam int NW = DIV_QW + FRAC_BITS;

  logic        ovf0;
  logic        zero0;
  logic [30:0] rem0;

  // The quotient fits 31 bits exactly when p < rho * 2^SH; zero density always lands here.
  assign ovf0  = (CW'(p) >= (CW'(rho) << SH));
  assign zero0 = (p == '0);
  assign rem0  = 31'(p >> SH);

  logic [30:0] rem_r  [DIV_STAGES];
  logic [30:0] q_r    [DIV_STAGES];
  logic [30:0] p_r    [DIV_STAGES];
  logic [30:0] rho_r  [DIV_STAGES];
  logic        ovf_r  [DIV_STAGES];
  logic        zero_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [30:0] rem_i, q_i, p_i, rho_i;
    logic        ovf_i, zero_i;
    logic [30:0] rem_nxt, q_nxt;

    if (s == 0) begin : g_first
      assign rem_i  = rem0;
      assign q_i    = '0;
      assign p_i    = p;
      assign rho_i  = rho;
      assign ovf_i  = ovf0;
      assign zero_i = zero0;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign q_i    = q_r[s-1];
      assign p_i    = p_r[s-1];
      assign rho_i  = rho_r[s-1];
      assign ovf_i  = ovf_r[s-1];
      assign zero_i = zero_r[s-1];
    end

    always_comb begin
      logic [31:0]   t;
      logic [NW-1:0] num;
      rem_nxt = rem_i;
      q_nxt   = q_i;
      num     = {p_i, {FRAC_BITS{1'b0}}};
      t       = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        if (s * DIV_BPS + b < DIV_QW) begin
          t = {rem_nxt, num[DIV_QW-1-(s*DIV_BPS+b)]};
          if (t >= {1'b0, rho_i}) begin
            t = t - {1'b0, rho_i};
            q_nxt[DIV_QW-1-(s*DIV_BPS+b)] = 1'b1;
          end
          rem_nxt = t[30:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        p_r[s]    <= p_i;
        rho_r[s]  <= rho_i;
        ovf_r[s]  <= ovf_i;
        zero_r[s] <= zero_i;
      end
    end
  end

  always_comb begin
    if (ovf_r[DIV_STAGES-1] && !zero_r[DIV_STAGES-1]) begin
      quo.clip = 1'b1;
      quo.val  = 32'sh7fffffff;
    end else if (ovf_r[DIV_STAGES-1]) begin
      quo.clip = 1'b0;
      quo.val  = '0;
    end else begin
      quo.clip = 1'b0;
      quo.val  = {1'b0, q_r[DIV_STAGES-1]};
    end
  end

endmodule

// File: hw/rtl/fcf_checker.sv
// Port-level checker for the boundary face flux block, bound to the top level.
// Depends on fcf_pkg and boundary_face_central_flux.
module fcf_checker import fcf_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tuser
);

  // Beats accepted but not yet delivered.
  logic [4:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 5'(in_tvalid && in_tready) - 5'(out_tvalid && out_tready);
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != 5'd0)
    else $error("output beat without an accepted input beat");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(NUM_STAGES))
    else $error("more beats in flight than pipeline stages");

endmodule

bind boundary_face_central_flux fcf_checker u_fcf_checker (.*);

// File: tb/tb_top.sv
// Self-checking testbench for boundary_face_central_flux: drives faces, predicts fluxes.
// Depends on fcf_pkg and the RTL of the block; nothing else.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fcf_pkg::*;

  localparam int LATENCY = 13;

  typedef struct {
    logic [1:0] side;
    logic signed [31:0] nx, ny;
    logic [30:0] rg; logic signed [31:0] ug, vg; logic [30:0] pg;
    logic [30:0] ri; logic signed [31:0] ui, vi; logic [30:0] pi;
  } face_t;

  typedef struct {
    logic signed [31:0] f0, f1, f2, f3;
    logic clip;
  } flux_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [319:0] in_tdata;
  logic [1:0] in_tuser;
  logic [127:0] out_tdata;
  logic cfg_wr_en;
  logic [EF_W-1:0] cfg_wr_data;

  boundary_face_central_flux dut (.*);

  face_t pending_faces[$];
  flux_t expected_fluxes[$];
  logic [EF_W-1:0] model_factor;
  int send_idle_pct, recv_stall_pct, hold_cycles, mismatches, sent;
  bit flux_clip;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Fixed-point helpers that mirror the block's number format.
  function automatic longint floor_shift(longint x, int s);
    return x >>> s;
  endfunction
  function automatic longint qm(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 15), 16);
  endfunction
  function automatic longint hv(longint x);
    return floor_shift(x + 1, 1);
  endfunction
  function automatic longint clip32(longint x);
    if (x > 64'sd2147483647) begin
      flux_clip = 1; return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      flux_clip = 1; return -64'sd2147483648;
    end
    return x;
  endfunction
  function automatic longint cell_enthalpy(longint r, longint u, longint v, longint p);
    longint q;
    if (r == 0) begin
      if (p != 0) begin
        flux_clip = 1; q = 64'sd2147483647;
      end else q = 0;
    end else q = clip32((p <<< 16) / r);
    return clip32(qm(longint'(model_factor), q) + hv(qm(u, u) + qm(v, v)));
  endfunction
  function automatic longint mass_rate(longint r, longint u, longint v,
                                       longint sx, longint sy);
    longint d;
    d = clip32(qm(u, sx) + qm(v, sy));
    return clip32(qm(d, r));
  endfunction

  function automatic flux_t face_flux(face_t f);
    flux_t o;
    longint sx, sy, hg, hi, qg, qi, pavg;
    flux_clip = 0;
    sx = f.nx; sy = f.ny;
    if (f.side == SIDE_RIGHT || f.side == SIDE_TOP) begin
      sx = clip32(-sx); sy = clip32(-sy);
    end
    hg = cell_enthalpy(f.rg, f.ug, f.vg, f.pg);
    hi = cell_enthalpy(f.ri, f.ui, f.vi, f.pi);
    qg = mass_rate(f.rg, f.ug, f.vg, sx, sy);
    qi = mass_rate(f.ri, f.ui, f.vi, sx, sy);
    pavg = hv(longint'(f.pg) + longint'(f.pi));
    o.f0 = 32'(clip32(hv(qg + qi)));
    o.f1 = 32'(clip32(hv(qm(qg, f.ug) + qm(qi, f.ui)) + qm(pavg, sx)));
    o.f2 = 32'(clip32(hv(qm(qg, f.vg) + qm(qi, f.vi)) + qm(pavg, sy)));
    o.f3 = 32'(clip32(hv(qm(qg, hg) + qm(qi, hi))));
    o.clip = flux_clip;
    return o;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'(int'($urandom_range(0, 1 << 20)))
                                     : -32'(int'($urandom_range(0, 1 << 20)));
      default: return $urandom;
    endcase
  endfunction
  function automatic logic [30:0] rnd31(bit nonzero);
    logic [30:0] v;
    case ($urandom_range(0, 4))
      0: v = 31'h7fff_ffff;
      1: v = nonzero ? 31'd1 : 31'd0;
      2: v = 31'($urandom_range(1 << 12, 1 << 20));
      default: v = 31'($urandom);
    endcase
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction
  function automatic face_t random_face();
    face_t f;
    f.side = 2'($urandom_range(0, 3));
    f.nx = rnd32(); f.ny = rnd32();
    f.rg = rnd31(1); f.ug = rnd32(); f.vg = rnd32(); f.pg = rnd31(0);
    f.ri = rnd31(1); f.ui = rnd32(); f.vi = rnd32(); f.pi = rnd31(0);
    // Zero density is allowed by the field, so hit it now and then.
    if ($urandom_range(0, 19) == 0) f.rg = 0;
    if ($urandom_range(0, 19) == 0) f.ri = 0;
    return f;
  endfunction

  // Driver: presents the head of the queue, with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_fluxes.push_back(face_flux(pending_faces.pop_front()));
        sent++;
      end
      if ((!in_tvalid || in_tready) && pending_faces.size() > 0
          && $urandom_range(0, 99) >= send_idle_pct) begin
        in_tvalid <= 1;
        in_tuser <= pending_faces[0].side;
        in_tdata <= {4'b0, pending_faces[0].pi, pending_faces[0].vi, pending_faces[0].ui,
                     pending_faces[0].ri, pending_faces[0].pg, pending_faces[0].vg,
                     pending_faces[0].ug, pending_faces[0].rg, pending_faces[0].ny,
                     pending_faces[0].nx};
      end else if (!in_tvalid || in_tready) begin
        in_tvalid <= 0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk) begin
    flux_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_fluxes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %h", out_tdata);
      end else begin
        exp_r = expected_fluxes.pop_front();
        if (out_tdata !== {exp_r.f3, exp_r.f2, exp_r.f1, exp_r.f0}
            || out_tuser !== exp_r.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Flux mismatch: expected %h sat %b, got %h sat %b",
                     {exp_r.f3, exp_r.f2, exp_r.f1, exp_r.f0}, exp_r.clip,
                     out_tdata, out_tuser);
        end
      end
    end
  end

  task automatic drain();
    wait (pending_faces.size() == 0 && !in_tvalid);
    wait (expected_fluxes.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_factor(logic [EF_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1; cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    model_factor = v;
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (n) pending_faces.push_back(random_face());
    drain();
  endtask

  initial begin
    face_t f;
    rst_n = 0; in_tvalid = 0; in_tdata = '0; in_tuser = '0;
    out_tready = 0; cfg_wr_en = 0; cfg_wr_data = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0;
    mismatches = 0; sent = 0;
    model_factor = EF_RESET;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed faces: every side, extreme normals, zero density and pressure.
    for (int s = 0; s < 4; s++) begin
      f = '{side: 2'(s), nx: 32'h0001_0000, ny: 32'h0, rg: 31'h1_0000, ug: 32'h2_0000,
            vg: -32'sh1_0000, pg: 31'h1_0000, ri: 31'h2_0000, ui: 32'h1_8000,
            vi: 32'h0, pi: 31'h3_0000};
      pending_faces.push_back(f);
      f.nx = 32'h8000_0000; f.ny = 32'h8000_0000;
      pending_faces.push_back(f);
    end
    f = '{side: 2'd0, nx: 32'h7fff_ffff, ny: 32'h7fff_ffff, rg: 31'h7fff_ffff,
          ug: 32'h7fff_ffff, vg: 32'h8000_0000, pg: 31'h7fff_ffff, ri: 31'd1,
          ui: 32'h8000_0000, vi: 32'h7fff_ffff, pi: 31'h7fff_ffff};
    pending_faces.push_back(f);
    f.rg = 0; f.ri = 0; pending_faces.push_back(f);
    f.pg = 0; pending_faces.push_back(f);
    f.pi = 0; f.side = 2'd3; pending_faces.push_back(f);
    f = '{side: 2'd2, nx: 0, ny: 0, rg: 31'd1, ug: 0, vg: 0, pg: 0,
          ri: 31'd1, ui: 0, vi: 0, pi: 0};
    pending_faces.push_back(f);
    drain();

    write_factor(21'd65536);
    random_phase(150, 0, 0);
    write_factor(21'd1048576);
    random_phase(150, 76, 0);
    write_factor(21'h1f_ffff);
    random_phase(50, 0, 76);
    write_factor(21'($urandom_range(65536, 1048576)));
    random_phase(100, 0, 76);
    write_factor(21'd0);
    random_phase(50, 29, 29);
    write_factor(EF_RESET);
    // Long receiver hold-off while the sender keeps offering faces.
    hold_cycles = 200;
    random_phase(100, 0, 0);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
